// ----- rtl/ucd_pkg.sv -----
// Shared types and constants for the uplink command deframer.
`timescale 1ns / 1ps

package ucd_pkg;

   localparam int MAX_PAYLOAD = 32;
   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 6;
   localparam int RATE_W      = 13;
   localparam int STATUS_W    = 3;
   localparam int ACTION_W    = 3;
   localparam int NUM_CODES   = 7;
   localparam int CODE_IDX_W  = 3;

   // Queue between parser and dispatcher; depth must be a power of two.
   localparam int FIFO_DEPTH  = 2;
   localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

   localparam logic [BYTE_W-1:0] SYNC_FIRST   = 8'hEB;
   localparam logic [BYTE_W-1:0] SYNC_SECOND  = 8'h90;
   localparam logic [BYTE_W-1:0] MAX_LEN_BYTE = BYTE_W'(MAX_PAYLOAD);

   localparam logic [RATE_W-1:0] RATE_MIN   = 13'd100;
   localparam logic [RATE_W-1:0] RATE_MAX   = 13'd5000;
   localparam logic [RATE_W-1:0] RATE_STEP  = 13'd100;
   localparam logic [RATE_W-1:0] RATE_RESET = 13'd500;

   // Shortcut keys, lower case; letters are compared with bit 5 forced high.
   localparam logic [BYTE_W-1:0] CASE_BIT   = 8'h20;
   localparam logic [BYTE_W-1:0] KEY_LED    = 8'h6C;  // l
   localparam logic [BYTE_W-1:0] KEY_STATUS = 8'h73;  // s
   localparam logic [BYTE_W-1:0] KEY_ARM    = 8'h61;  // a
   localparam logic [BYTE_W-1:0] KEY_DUMP   = 8'h64;  // d
   localparam logic [BYTE_W-1:0] KEY_ERASE  = 8'h65;  // e
   localparam logic [BYTE_W-1:0] KEY_PLUS   = 8'h2B;  // +
   localparam logic [BYTE_W-1:0] KEY_MINUS  = 8'h2D;  // -

   // Register index of each command code; IDX_NONE means no code matched.
   typedef enum logic [CODE_IDX_W-1:0] {
      IDX_NOOP, IDX_LED, IDX_STATUS, IDX_SET_RATE,
      IDX_ARM, IDX_DUMP, IDX_ERASE, IDX_NONE
   } code_idx_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ACK, ST_BAD_LEN, ST_CKSUM_ERR, ST_UNKNOWN, ST_TOO_LONG
   } status_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_NONE, ACT_NOOP, ACT_LED, ACT_STATUS,
      ACT_ARM, ACT_DUMP, ACT_ERASE, ACT_RATE
   } action_type;

   typedef enum logic [2:0] {
      PH_IDLE, PH_SYNC, PH_ID, PH_LEN, PH_PAYLOAD, PH_CKSUM
   } phase_type;

   typedef enum logic [2:0] {
      JOB_FRAME, JOB_SHORT, JOB_PLUS, JOB_MINUS, JOB_TOO_LONG, JOB_CKSUM_ERR
   } job_kind_type;

   // One classified command handed from parser to dispatcher.
   typedef struct packed {
      job_kind_type        kind;
      logic [BYTE_W-1:0]   id;
      code_idx_type        sel;
      logic                len_ok;
      logic [BYTE_W-1:0]   pay_lo;
      logic [BYTE_W-1:0]   pay_hi;
   } job_type;

endpackage

// ----- rtl/ucd_req_if.sv -----
// Byte request channel into the deframer.
`timescale 1ns / 1ps

interface ucd_req_if import ucd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/ucd_rsp_if.sv -----
// Response channel out of the deframer.
`timescale 1ns / 1ps

interface ucd_rsp_if import ucd_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   cmd_code;
   logic [STATUS_W-1:0] status;
   logic [ACTION_W-1:0] action;
   logic [RATE_W-1:0]   rate_ms;

   modport source (output valid, output cmd_code, output status, output action,
                   output rate_ms, input ready);
   modport sink   (input valid, input cmd_code, input status, input action,
                   input rate_ms, output ready);
endinterface

// ----- rtl/ucd_csr_if.sv -----
// Command code register write channel.
`timescale 1ns / 1ps

interface ucd_csr_if import ucd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CODE_IDX_W-1:0] index;
   logic [BYTE_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/ucd_front.sv -----
// Frame parser: tracks sync, header, payload and checksum, emits jobs.
`timescale 1ns / 1ps

module ucd_front import ucd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   ucd_req_if.sink   req_chan,
   input  logic      fifo_full,
   output logic      job_push,
   output job_type   job
);

   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] id_ff, id_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  seen_ff, seen_in;
   logic [BYTE_W-1:0] xor_ff, xor_in;
   logic [BYTE_W-1:0] lo_ff, lo_in;
   logic [BYTE_W-1:0] hi_ff, hi_in;

   logic              accept;
   logic [BYTE_W-1:0] b;
   logic [BYTE_W-1:0] folded;
   logic              sc_hit;
   job_type           sc_job;
   logic [LEN_W-1:0]  seen_inc;

   assign req_chan.ready = !fifo_full;
   assign accept = req_chan.valid && req_chan.ready;
   assign b = req_chan.rx_byte;
   assign folded = b | CASE_BIT;
   assign seen_inc = seen_ff + LEN_W'(1);

   // shortcut decode
   always_comb begin
      sc_hit = 1'b1;
      sc_job = '{kind: JOB_SHORT, id: b, sel: IDX_NONE, len_ok: 1'b0,
                 pay_lo: lo_ff, pay_hi: hi_ff};
      if (b == KEY_PLUS) begin
         sc_job.kind = JOB_PLUS;
      end else if (b == KEY_MINUS) begin
         sc_job.kind = JOB_MINUS;
      end else begin
         case (folded)
            KEY_LED:    sc_job.sel = IDX_LED;
            KEY_STATUS: sc_job.sel = IDX_STATUS;
            KEY_ARM:    sc_job.sel = IDX_ARM;
            KEY_DUMP:   sc_job.sel = IDX_DUMP;
            KEY_ERASE:  sc_job.sel = IDX_ERASE;
            default:    sc_hit = 1'b0;
         endcase
      end
   end

   always_comb begin
      phase_in = phase_ff;
      id_in    = id_ff;
      len_in   = len_ff;
      seen_in  = seen_ff;
      xor_in   = xor_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      job_push = 1'b0;
      job      = sc_job;
      if (accept) begin
         case (phase_ff)
            PH_IDLE: begin
               if (b == SYNC_FIRST) begin
                  phase_in = PH_SYNC;
               end else begin
                  job_push = sc_hit;
               end
            end
            PH_SYNC: begin
               if (b == SYNC_SECOND) begin
                  phase_in = PH_ID;
               end else if (b != SYNC_FIRST) begin
                  phase_in = PH_IDLE;
                  job_push = sc_hit;
               end
            end
            PH_ID: begin
               id_in    = b;
               xor_in   = b;
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               seen_in = '0;
               lo_in   = '0;
               hi_in   = '0;
               if (b > MAX_LEN_BYTE) begin
                  phase_in = PH_IDLE;
                  job_push = 1'b1;
                  job      = '{kind: JOB_TOO_LONG, id: id_ff, sel: IDX_NONE,
                               len_ok: 1'b0, pay_lo: lo_ff, pay_hi: hi_ff};
               end else begin
                  len_in   = b[LEN_W-1:0];
                  xor_in   = xor_ff ^ b;
                  phase_in = (b == '0) ? PH_CKSUM : PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               if (seen_ff == LEN_W'(0)) begin
                  lo_in = b;
               end else if (seen_ff == LEN_W'(1)) begin
                  hi_in = b;
               end
               xor_in  = xor_ff ^ b;
               seen_in = seen_inc;
               if (seen_inc >= len_ff) begin
                  phase_in = PH_CKSUM;
               end
            end
            PH_CKSUM: begin
               phase_in = PH_IDLE;
               job_push = 1'b1;
               job      = '{kind: (b != xor_ff) ? JOB_CKSUM_ERR : JOB_FRAME,
                            id: id_ff, sel: IDX_NONE,
                            len_ok: (len_ff >= LEN_W'(2)),
                            pay_lo: lo_ff, pay_hi: hi_ff};
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         id_ff    <= '0;
         len_ff   <= '0;
         seen_ff  <= '0;
         xor_ff   <= '0;
         lo_ff    <= '0;
         hi_ff    <= '0;
      end else begin
         phase_ff <= phase_in;
         id_ff    <= id_in;
         len_ff   <= len_in;
         seen_ff  <= seen_in;
         xor_ff   <= xor_in;
         lo_ff    <= lo_in;
         hi_ff    <= hi_in;
      end
   end

endmodule

// ----- rtl/ucd_fifo.sv -----
// Short job queue between parser and dispatcher.
`timescale 1ns / 1ps

module ucd_fifo import ucd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    full,
   output logic    not_empty,
   output job_type head_job
);

   job_type               mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff;
   logic [FIFO_CNT_W-1:0] count_ff;

   assign full      = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_job  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + FIFO_CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - FIFO_CNT_W'(1);
         end
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("job queue count out of range");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("job pushed into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("job popped from empty queue");
`endif

endmodule

// ----- rtl/ucd_back.sv -----
// Dispatcher: resolves command codes, keeps the telemetry period, drives responses.
`timescale 1ns / 1ps

module ucd_back import ucd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   ucd_csr_if.sink   csr_chan,
   ucd_rsp_if.source rsp_chan,
   input  logic      job_valid,
   input  job_type   job,
   output logic      job_pop
);

   logic [BYTE_W-1:0]   codes_ff [NUM_CODES];
   logic [RATE_W-1:0]   period_ff, period_in;
   logic                rsp_valid_ff;
   logic [BYTE_W-1:0]   code_ff, code_in;
   status_type          status_ff, status_in;
   action_type          action_ff, action_in;

   code_idx_type        hit;
   logic [2*BYTE_W-1:0] raw;
   logic [RATE_W-1:0]   clamped;

   assign csr_chan.ready = 1'b1;
   assign job_pop = job_valid && (!rsp_valid_ff || rsp_chan.ready);

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.cmd_code = code_ff;
   assign rsp_chan.status   = status_ff;
   assign rsp_chan.action   = action_ff;
   assign rsp_chan.rate_ms  = period_ff;

   always_comb begin
      code_in = job.id;
      case (job.kind)
         JOB_SHORT:            code_in = codes_ff[job.sel];
         JOB_PLUS, JOB_MINUS:  code_in = codes_ff[IDX_SET_RATE];
         default:              code_in = job.id;
      endcase

      // first matching register wins
      hit = IDX_NONE;
      for (int i = NUM_CODES - 1; i >= 0; i--) begin
         if (codes_ff[i] == code_in) begin
            hit = code_idx_type'(i);
         end
      end

      raw = {job.pay_hi, job.pay_lo};
      if (raw < (2*BYTE_W)'(RATE_MIN)) begin
         clamped = RATE_MIN;
      end else if (raw > (2*BYTE_W)'(RATE_MAX)) begin
         clamped = RATE_MAX;
      end else begin
         clamped = raw[RATE_W-1:0];
      end

      period_in = period_ff;
      status_in = ST_ACK;
      action_in = ACT_NONE;
      case (job.kind)
         JOB_PLUS: begin
            if (period_ff > RATE_MIN) begin
               period_in = period_ff - RATE_STEP;
            end
            action_in = ACT_RATE;
         end
         JOB_MINUS: begin
            if (period_ff < RATE_MAX) begin
               period_in = period_ff + RATE_STEP;
            end
            action_in = ACT_RATE;
         end
         JOB_TOO_LONG:  status_in = ST_TOO_LONG;
         JOB_CKSUM_ERR: status_in = ST_CKSUM_ERR;
         default: begin
            case (hit)
               IDX_NOOP:   action_in = ACT_NOOP;
               IDX_LED:    action_in = ACT_LED;
               IDX_STATUS: action_in = ACT_STATUS;
               IDX_SET_RATE: begin
                  if (!job.len_ok) begin
                     status_in = ST_BAD_LEN;
                  end else begin
                     period_in = clamped;
                     action_in = ACT_RATE;
                  end
               end
               IDX_ARM:    action_in = ACT_ARM;
               IDX_DUMP:   action_in = ACT_DUMP;
               IDX_ERASE:  action_in = ACT_ERASE;
               default:    status_in = ST_UNKNOWN;
            endcase
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CODES; i++) begin
            codes_ff[i] <= BYTE_W'(i);
         end
      end else if (csr_chan.valid && (csr_chan.index < CODE_IDX_W'(NUM_CODES))) begin
         codes_ff[csr_chan.index] <= csr_chan.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         period_ff    <= RATE_RESET;
      end else begin
         if (job_pop) begin
            rsp_valid_ff <= 1'b1;
            period_ff    <= period_in;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         code_ff   <= code_in;
         status_ff <= status_in;
         action_ff <= action_in;
      end
   end

`ifndef SYNTHESIS
   // '+' from just above the floor can leave the period anywhere in 1..99
   a_period_range: assert property (@(posedge clock) disable iff (reset)
      (period_ff != '0) && (period_ff < RATE_MAX + RATE_STEP))
      else $error("telemetry period out of range");

   a_nack_no_action: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff != ST_ACK) |-> (action_ff == ACT_NONE))
      else $error("error status carries an action");

   a_stall_period: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |=> $stable(period_ff))
      else $error("period changed while response stalled");
`endif

endmodule

// ----- rtl/uplink_command_deframer.sv -----
// Top level of the uplink command deframer: parser, job queue, dispatcher.
// A byte that yields a response passes the job queue and the response register first.
// Throughput: one byte per cycle while the two-entry job queue has room; the dispatcher
// retires one job per cycle into the response register when it is empty or taken.
// Reset (synchronous, active high): parser idle, queue empty, no response pending,
// command codes back to 0..6 and telemetry period back to 500 ms.
`timescale 1ns / 1ps

module uplink_command_deframer import ucd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   ucd_req_if.sink   req_chan,
   ucd_rsp_if.source rsp_chan,
   ucd_csr_if.sink   csr_chan
);

   // Parser to queue: one classified request per framed command or shortcut.
   logic    job_push;
   job_type push_job;
   // Queue to dispatcher.
   logic    fifo_full;
   logic    job_valid;
   logic    job_pop;
   job_type head_job;

   // Front: sync hunt, header and payload capture, running XOR.
   ucd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .fifo_full (fifo_full),
      .job_push  (job_push),
      .job       (push_job)
   );

   // Decouples a stalled response from byte intake.
   ucd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_job  (push_job),
      .pop       (job_pop),
      .full      (fifo_full),
      .not_empty (job_valid),
      .head_job  (head_job)
   );

   // Back: code lookup, rate update, registered response.
   ucd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_chan  (csr_chan),
      .rsp_chan  (rsp_chan),
      .job_valid (job_valid),
      .job       (head_job),
      .job_pop   (job_pop)
   );

endmodule

// ----- test/uplink_command_deframer_tb.sv -----
// Self-checking testbench for the uplink command deframer.
`timescale 1ns / 1ps

module uplink_command_deframer_tb;
   import ucd_pkg::*;

   // Run guard, far above the slowest legal run.
   localparam int CYCLE_LIMIT = 400000;
   // Drain wait after the last response.
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_BYTES = 200;
   localparam int NUM_PHASES = 7;
   localparam int IDLE_PCT = 38;
   localparam int MAX_REPORTS = 100;
   // '?' is a help key upstream; here it must give no response.
   localparam logic [BYTE_W-1:0] KEY_HELP = 8'h3F;

   // One response as the deframer should present it.
   typedef struct packed {
      logic [BYTE_W-1:0] cmd;
      status_type        status;
      action_type        action;
      logic [RATE_W-1:0] rate;
   } rsp_t;

   // One row of the directed script; typed rows carry a hand-written answer.
   typedef struct {
      logic [BYTE_W-1:0] data;
      bit                typed;
      bit                has_rsp;
      rsp_t              exp;
   } row_t;

   logic clock;
   logic reset;

   ucd_req_if req_if ();
   ucd_rsp_if rsp_if ();
   ucd_csr_if csr_if ();

   uplink_command_deframer u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // ---------------------------------------------------------------
   // Predictor state: a private copy of the parser, code table and period.
   // ---------------------------------------------------------------
   logic [BYTE_W-1:0] code_reg [NUM_CODES];
   phase_type         pr_phase;
   logic [BYTE_W-1:0] pr_id;
   logic [LEN_W-1:0]  pr_len;
   logic [LEN_W-1:0]  pr_seen;
   logic [BYTE_W-1:0] pr_xsum;
   logic [BYTE_W-1:0] pr_lo;
   logic [BYTE_W-1:0] pr_hi;
   logic [RATE_W-1:0] pr_period;

   rsp_t pending_rsp [$];
   row_t script [$];
   logic [BYTE_W-1:0] no_bytes [$];
   logic [BYTE_W-1:0] big_pay [$];

   int  mismatches;
   int  bytes_sent;
   int  cycle_count;
   bit  calm;          // when set, neither side idles
   rsp_t seen_exp;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void reset_model();
      for (int k = 0; k < NUM_CODES; k++) code_reg[k] = BYTE_W'(k);
      pr_phase  = PH_IDLE;
      pr_id     = '0;
      pr_len    = '0;
      pr_seen   = '0;
      pr_xsum   = '0;
      pr_lo     = '0;
      pr_hi     = '0;
      pr_period = RATE_RESET;
   endfunction

   // Command dispatch: first matching code register wins.
   function automatic void run_dispatch(input logic [BYTE_W-1:0] id, input int len,
                                        output rsp_t r);
      int k;
      logic [15:0] v;
      k = 0;
      while (k < NUM_CODES && code_reg[k] != id) k++;
      r.cmd    = id;
      r.status = ST_ACK;
      r.action = ACT_NONE;
      case (code_idx_type'(k))
         IDX_NOOP:   r.action = ACT_NOOP;
         IDX_LED:    r.action = ACT_LED;
         IDX_STATUS: r.action = ACT_STATUS;
         IDX_SET_RATE: begin
            if (len < 2) begin
               r.status = ST_BAD_LEN;
            end else begin
               v = {pr_hi, pr_lo};
               if (v < RATE_MIN) v = RATE_MIN;
               if (v > RATE_MAX) v = RATE_MAX;
               pr_period = v[RATE_W-1:0];
               r.action  = ACT_RATE;
            end
         end
         IDX_ARM:    r.action = ACT_ARM;
         IDX_DUMP:   r.action = ACT_DUMP;
         IDX_ERASE:  r.action = ACT_ERASE;
         default:    r.status = ST_UNKNOWN;
      endcase
      r.rate = pr_period;
   endfunction

   function automatic bit is_key(input logic [BYTE_W-1:0] b, input logic [BYTE_W-1:0] key);
      return b == key || b == (key ^ CASE_BIT);
   endfunction

   // Single-letter shortcuts outside a frame; they carry an empty payload.
   function automatic bit run_shortcut(input logic [BYTE_W-1:0] b, output rsp_t r);
      r = '0;
      if (is_key(b, KEY_LED)) begin
         run_dispatch(code_reg[IDX_LED], 0, r);
      end else if (is_key(b, KEY_STATUS)) begin
         run_dispatch(code_reg[IDX_STATUS], 0, r);
      end else if (is_key(b, KEY_ARM)) begin
         run_dispatch(code_reg[IDX_ARM], 0, r);
      end else if (is_key(b, KEY_DUMP)) begin
         run_dispatch(code_reg[IDX_DUMP], 0, r);
      end else if (is_key(b, KEY_ERASE)) begin
         run_dispatch(code_reg[IDX_ERASE], 0, r);
      end else if (b == KEY_PLUS || b == KEY_MINUS) begin
         // '+' shortens the period, '-' lengthens it; the bounds are checked
         // before the step, so the period can end up just outside 100..5000.
         if (b == KEY_PLUS && pr_period > RATE_MIN) pr_period = pr_period - RATE_STEP;
         if (b == KEY_MINUS && pr_period < RATE_MAX) pr_period = pr_period + RATE_STEP;
         r.cmd    = code_reg[IDX_SET_RATE];
         r.status = ST_ACK;
         r.action = ACT_RATE;
         r.rate   = pr_period;
      end else begin
         return 1'b0;
      end
      return 1'b1;
   endfunction

   // Predictor for one accepted byte; returns 1 when a response is due.
   function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output rsp_t r);
      r = '0;
      case (pr_phase)
         PH_IDLE: begin
            if (b == SYNC_FIRST) begin
               pr_phase = PH_SYNC;
               return 1'b0;
            end
            return run_shortcut(b, r);
         end
         PH_SYNC: begin
            if (b == SYNC_SECOND) begin
               pr_phase = PH_ID;
               return 1'b0;
            end
            // A repeated sync byte keeps waiting; anything else is a shortcut.
            if (b == SYNC_FIRST) return 1'b0;
            pr_phase = PH_IDLE;
            return run_shortcut(b, r);
         end
         PH_ID: begin
            pr_id    = b;
            pr_xsum  = b;
            pr_phase = PH_LEN;
            return 1'b0;
         end
         PH_LEN: begin
            pr_seen = '0;
            pr_lo   = '0;
            pr_hi   = '0;
            if (b > MAX_LEN_BYTE) begin
               pr_phase = PH_IDLE;
               r.cmd    = pr_id;
               r.status = ST_TOO_LONG;
               r.action = ACT_NONE;
               r.rate   = pr_period;
               return 1'b1;
            end
            pr_len   = b[LEN_W-1:0];
            pr_xsum  = pr_xsum ^ b;
            pr_phase = (b == 8'd0) ? PH_CKSUM : PH_PAYLOAD;
            return 1'b0;
         end
         PH_PAYLOAD: begin
            if (pr_seen == 0) pr_lo = b;
            else if (pr_seen == 1) pr_hi = b;
            pr_xsum = pr_xsum ^ b;
            pr_seen = pr_seen + 1'b1;
            if (pr_seen >= pr_len) pr_phase = PH_CKSUM;
            return 1'b0;
         end
         PH_CKSUM: begin
            pr_phase = PH_IDLE;
            if (b != pr_xsum) begin
               r.cmd    = pr_id;
               r.status = ST_CKSUM_ERR;
               r.action = ACT_NONE;
               r.rate   = pr_period;
               return 1'b1;
            end
            run_dispatch(pr_id, int'(pr_len), r);
            return 1'b1;
         end
         default: begin
            pr_phase = PH_IDLE;
            return 1'b0;
         end
      endcase
   endfunction

   // ---------------------------------------------------------------
   // Directed script construction.
   // ---------------------------------------------------------------
   function automatic void add_row(input logic [BYTE_W-1:0] b);
      row_t r;
      r.data    = b;
      r.typed   = 1'b0;
      r.has_rsp = 1'b0;
      r.exp     = '0;
      script.push_back(r);
   endfunction

   // Pins the answer of the last row added.
   function automatic void typed_last(input bit has, input logic [BYTE_W-1:0] cmd,
                                      input status_type st, input action_type act,
                                      input logic [RATE_W-1:0] rate);
      script[$].typed      = 1'b1;
      script[$].has_rsp    = has;
      script[$].exp.cmd    = cmd;
      script[$].exp.status = st;
      script[$].exp.action = act;
      script[$].exp.rate   = rate;
   endfunction

   function automatic void add_typed(input logic [BYTE_W-1:0] b, input bit has,
                                     input logic [BYTE_W-1:0] cmd, input status_type st,
                                     input action_type act, input logic [RATE_W-1:0] rate);
      add_row(b);
      typed_last(has, cmd, st, act, rate);
   endfunction

   // Whole frame, checksum optionally spoiled.
   function automatic void add_frame(input logic [BYTE_W-1:0] id,
                                     input logic [BYTE_W-1:0] pay [$], input bit corrupt);
      logic [BYTE_W-1:0] sum;
      add_row(SYNC_FIRST);
      add_row(SYNC_SECOND);
      add_row(id);
      add_row(BYTE_W'(pay.size()));
      sum = id ^ BYTE_W'(pay.size());
      foreach (pay[i]) begin
         add_row(pay[i]);
         sum = sum ^ pay[i];
      end
      add_row(corrupt ? ~sum : sum);
   endfunction

   function automatic void build_script();
      // Every shortcut with reset codes and the 500 ms reset period.
      add_typed(KEY_LED, 1, 8'd1, ST_ACK, ACT_LED, 13'd500);
      add_typed(KEY_STATUS ^ CASE_BIT, 1, 8'd2, ST_ACK, ACT_STATUS, 13'd500);
      add_typed(KEY_ARM, 1, 8'd4, ST_ACK, ACT_ARM, 13'd500);
      add_typed(KEY_DUMP ^ CASE_BIT, 1, 8'd5, ST_ACK, ACT_DUMP, 13'd500);
      add_typed(KEY_ERASE, 1, 8'd6, ST_ACK, ACT_ERASE, 13'd500);
      add_typed(KEY_PLUS, 1, 8'd3, ST_ACK, ACT_RATE, 13'd400);
      add_typed(KEY_MINUS, 1, 8'd3, ST_ACK, ACT_RATE, 13'd500);
      add_typed(KEY_HELP, 0, 8'd0, ST_ACK, ACT_NONE, 13'd0);
      // False sync: the sync byte is dropped, the next byte acts as a shortcut.
      add_row(SYNC_FIRST);
      add_typed(KEY_ARM ^ CASE_BIT, 1, 8'd4, ST_ACK, ACT_ARM, 13'd500);
      add_row(SYNC_FIRST);
      add_row(8'h00);
      // Doubled sync byte, then an empty noop frame.
      add_row(SYNC_FIRST);
      add_frame(8'd0, no_bytes, 0);
      typed_last(1, 8'd0, ST_ACK, ACT_NOOP, 13'd500);
      // Set rate clamped high and low, and the step guards at the bounds.
      add_frame(8'd3, '{8'h10, 8'h27}, 0);
      typed_last(1, 8'd3, ST_ACK, ACT_RATE, 13'd5000);
      add_typed(KEY_MINUS, 1, 8'd3, ST_ACK, ACT_RATE, 13'd5000);
      add_frame(8'd3, '{8'h05, 8'h00}, 0);
      typed_last(1, 8'd3, ST_ACK, ACT_RATE, 13'd100);
      add_typed(KEY_PLUS, 1, 8'd3, ST_ACK, ACT_RATE, 13'd100);
      // Set rate with one payload byte: bad length, period kept.
      add_frame(8'd3, '{8'h55}, 0);
      typed_last(1, 8'd3, ST_BAD_LEN, ACT_NONE, 13'd100);
      // Length above the limit, just over and at the top of the byte.
      add_row(SYNC_FIRST);
      add_row(SYNC_SECOND);
      add_row(8'h07);
      add_typed(MAX_LEN_BYTE + 8'd1, 1, 8'h07, ST_TOO_LONG, ACT_NONE, 13'd100);
      add_row(SYNC_FIRST);
      add_row(SYNC_SECOND);
      add_row(8'hFF);
      add_typed(8'hFF, 1, 8'hFF, ST_TOO_LONG, ACT_NONE, 13'd100);
      add_frame(8'd1, no_bytes, 1);
      typed_last(1, 8'd1, ST_CKSUM_ERR, ACT_NONE, 13'd100);
      add_frame(8'hFF, no_bytes, 0);
      typed_last(1, 8'hFF, ST_UNKNOWN, ACT_NONE, 13'd100);
      add_frame(8'd3, '{8'hFF, 8'hFF}, 0);
      typed_last(1, 8'd3, ST_ACK, ACT_RATE, 13'd5000);
      // Trailing payload bytes past the second are ignored for the rate.
      add_frame(8'd3, '{8'hC8, 8'h00, 8'hFF}, 0);
      // Longest legal payload, content random.
      for (int i = 0; i < MAX_PAYLOAD; i++) big_pay.push_back(BYTE_W'($urandom));
      add_frame(8'd2, big_pay, 0);
   endfunction

   // ---------------------------------------------------------------
   // Request and register drivers; each is entered at a falling edge.
   // ---------------------------------------------------------------
   task automatic send_byte(input logic [BYTE_W-1:0] b, output bit got, output rsp_t pr);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.rx_byte <= b;
      do begin
         @(posedge clock);
      end while (!req_if.ready);
      bytes_sent++;
      got = deframe_byte(b, pr);
      @(negedge clock);
   endtask

   task automatic feed_byte(input logic [BYTE_W-1:0] b);
      bit   got;
      rsp_t pr;
      send_byte(b, got, pr);
      if (got) pending_rsp.push_back(pr);
   endtask

   task automatic write_code(input code_idx_type idx, input logic [BYTE_W-1:0] val);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      do begin
         @(posedge clock);
      end while (!csr_if.ready);
      // Index 7 lies past the code table; the block drops it.
      if (idx != IDX_NONE) code_reg[int'(idx)] = val;
      @(negedge clock);
   endtask

   // Wait out every pending response plus the pipeline, end on a falling edge.
   task automatic wait_drained();
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------
   // Random stimulus.
   // ---------------------------------------------------------------
   function automatic logic [BYTE_W-1:0] pick_key();
      logic [BYTE_W-1:0] key;
      int k;
      k = $urandom_range(7);
      case (k)
         0: key = KEY_LED;
         1: key = KEY_STATUS;
         2: key = KEY_ARM;
         3: key = KEY_DUMP;
         4: key = KEY_ERASE;
         5: key = KEY_PLUS;
         6: key = KEY_MINUS;
         default: key = KEY_HELP;
      endcase
      if (k < 5 && $urandom_range(1)) key = key ^ CASE_BIT;
      return key;
   endfunction

   // Mostly well-formed frames; ids lean on the live code table.
   task automatic send_frame();
      logic [BYTE_W-1:0] id;
      logic [BYTE_W-1:0] len;
      logic [BYTE_W-1:0] sum;
      logic [BYTE_W-1:0] b;
      logic [15:0] rv;
      int k;
      int n;
      k = $urandom_range(NUM_CODES);
      id = (k == NUM_CODES) ? BYTE_W'($urandom) : code_reg[k];
      n = $urandom_range(99);
      if (n < 8) len = BYTE_W'($urandom_range(255, MAX_PAYLOAD + 1));
      else if (n < 20) len = BYTE_W'($urandom_range(MAX_PAYLOAD, 5));
      else if (n < 23) len = MAX_LEN_BYTE;
      else len = BYTE_W'($urandom_range(4, 0));
      case ($urandom_range(3))
         0: rv = 16'($urandom_range(99, 0));
         1: rv = 16'($urandom_range(5000, 100));
         2: rv = 16'($urandom_range(65535, 5001));
         default: rv = 16'($urandom);
      endcase
      feed_byte(SYNC_FIRST);
      feed_byte(SYNC_SECOND);
      feed_byte(id);
      feed_byte(len);
      if (len > MAX_LEN_BYTE) return;
      sum = id ^ len;
      for (int i = 0; i < int'(len); i++) begin
         b = (i == 0) ? rv[7:0] : (i == 1) ? rv[15:8] : BYTE_W'($urandom);
         sum = sum ^ b;
         feed_byte(b);
      end
      if ($urandom_range(99) < 12) sum = sum ^ BYTE_W'($urandom_range(255, 1));
      feed_byte(sum);
   endtask

   task automatic send_random();
      int n;
      logic [BYTE_W-1:0] b;
      n = $urandom_range(99);
      if (n < 70) begin
         send_frame();
      end else if (n < 82) begin
         feed_byte(pick_key());
      end else if (n < 91) begin
         feed_byte(BYTE_W'($urandom));
      end else begin
         // Broken starts: lone sync byte, doubled sync, sync then shortcut.
         feed_byte(SYNC_FIRST);
         case ($urandom_range(2))
            0: begin
               b = BYTE_W'($urandom);
               if (b == SYNC_SECOND) b = SYNC_FIRST;
               feed_byte(b);
            end
            1: send_frame();
            default: feed_byte(pick_key());
         endcase
      end
   endtask

   // Code table settings per random phase: extremes, collisions, sync-like values.
   task automatic load_setting(input int ph);
      logic [BYTE_W-1:0] vals [NUM_CODES];
      for (int k = 0; k < NUM_CODES; k++) begin
         case (ph)
            0: vals[k] = 8'hFF - BYTE_W'(k);
            // set_rate shadows arm/dump/erase: those shortcuts hit set-rate, empty
            1: vals[k] = (k < 3) ? BYTE_W'(9 - k) : 8'd6;
            2: vals[k] = 8'h00;
            3: vals[k] = BYTE_W'($urandom);
            4: vals[k] = BYTE_W'($urandom_range(7, 0));
            5: begin
               case (k)
                  0: vals[k] = SYNC_SECOND;
                  1: vals[k] = SYNC_FIRST;
                  2: vals[k] = 8'h00;
                  3: vals[k] = 8'hFF;
                  4: vals[k] = KEY_PLUS;
                  5: vals[k] = KEY_LED;
                  default: vals[k] = 8'h7F;
               endcase
            end
            default: vals[k] = BYTE_W'(k);
         endcase
      end
      for (int k = 0; k < NUM_CODES; k++) write_code(code_idx_type'(k), vals[k]);
      write_code(IDX_NONE, BYTE_W'($urandom));
      csr_if.valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------
   // Response side: random back-pressure, checks in order of requests.
   // ---------------------------------------------------------------
   task automatic flag_mismatch(input string what);
      if (mismatches < MAX_REPORTS) $display("ERROR at %0t ns: %s", $time, what);
      mismatches++;
   endtask

   always @(negedge clock) begin
      rsp_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_rsp.size() == 0) begin
            flag_mismatch($sformatf("unexpected response code %0h status %0d",
                                    rsp_if.cmd_code, rsp_if.status));
         end else begin
            seen_exp = pending_rsp.pop_front();
            if (rsp_if.cmd_code !== seen_exp.cmd)
               flag_mismatch($sformatf("cmd_code %0h, want %0h",
                                       rsp_if.cmd_code, seen_exp.cmd));
            if (rsp_if.status !== seen_exp.status)
               flag_mismatch($sformatf("status %0d, want %s (code %0h)",
                                       rsp_if.status, seen_exp.status.name(), seen_exp.cmd));
            if (rsp_if.action !== seen_exp.action)
               flag_mismatch($sformatf("action %0d, want %s (code %0h)",
                                       rsp_if.action, seen_exp.action.name(), seen_exp.cmd));
            if (rsp_if.rate_ms !== seen_exp.rate)
               flag_mismatch($sformatf("rate_ms %0d, want %0d (code %0h)",
                                       rsp_if.rate_ms, seen_exp.rate, seen_exp.cmd));
         end
      end
   end

   // Hang guard.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Main sequence: reset, directed script, then randomized phases.
   // ---------------------------------------------------------------
   initial begin
      bit   got;
      rsp_t pr;
      int   phase_end;
      mismatches     = 0;
      bytes_sent     = 0;
      cycle_count    = 0;
      calm           = 1'b0;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.rx_byte = '0;
      rsp_if.ready   = 1'b0;
      csr_if.valid   = 1'b0;
      csr_if.index   = IDX_NOOP;
      csr_if.data    = '0;
      reset_model();
      build_script();

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed script with reset codes; pinned rows override the predictor,
      // which still runs on every byte to keep its state in step.
      foreach (script[i]) begin
         send_byte(script[i].data, got, pr);
         if (script[i].typed) begin
            if (script[i].has_rsp) pending_rsp.push_back(script[i].exp);
         end else if (got) begin
            pending_rsp.push_back(pr);
         end
      end
      req_if.valid <= 1'b0;

      // Random phases, code table rewritten only while the block is quiet.
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_drained();
         load_setting(ph);
         @(negedge clock);
         calm = (ph == 3);
         phase_end = bytes_sent + PHASE_BYTES;
         while (bytes_sent < phase_end) send_random();
         req_if.valid <= 1'b0;
         calm = 1'b0;
      end

      wait_drained();
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
